// ----- rtl/core/kstb_pkg.sv -----
// ----------------------------------------------------------------------------
// kstb_pkg
// Shared types and constants for the keyed software timer bank.
// ----------------------------------------------------------------------------
package kstb_pkg;

  localparam int SLOT_COUNT_DEF = 16;

  localparam int KEY_W  = 16;
  localparam int MS_W   = 32;
  localparam int INC_W  = 16;
  localparam int REQ_W  = 2;

  localparam logic [INC_W-1:0] TICK_RESET = 16'd10;

  // request codes; code 3 is unused: it leaves the table as is and returns an all-zero result
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CHECK   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DESTROY = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] timer_key;
    logic [MS_W-1:0]  target_ms;
  } in_item_t;

  typedef struct packed {
    logic            expired;
    logic [MS_W-1:0] elapsed_ms;
    logic            table_full;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;   // latch the accepted transaction, clear search state
    logic scan_rd;     // read slot memories at scan index
    logic scan_proc;   // process data read in the previous cycle
    logic commit;      // update table and load the output register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
  } dp_status_t;

endpackage

// ----- rtl/core/kstb_ctrl.sv -----
// ----------------------------------------------------------------------------
// kstb_ctrl
// Sequencer: accepts one transaction, sweeps all slots, then commits.
// ----------------------------------------------------------------------------
module kstb_ctrl
  import kstb_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int CNTW = $clog2(SLOT_COUNT + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  dp_status_t      status,
  output ctl_cmd_t        cmd,
  output logic [CNTW-1:0] scan_idx
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            scan_end;

  assign scan_end = (cnt_r == CNTW'(SLOT_COUNT));
  assign scan_idx = cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        // each slot read is processed in the cycle after it
        cmd.scan_rd   = !scan_end;
        cmd.scan_proc = (cnt_r != '0);
        cnt_nxt       = cnt_r + CNTW'(1);
        if (scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/kstb_dp.sv -----
// ----------------------------------------------------------------------------
// kstb_dp
// Slot storage, key search, saturating tick update and result register.
// ----------------------------------------------------------------------------
module kstb_dp
  import kstb_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int CNTW = $clog2(SLOT_COUNT + 1),
  localparam int IDXW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [INC_W-1:0] cfg_wr_data,
  input  in_item_t         in_data,
  input  ctl_cmd_t         cmd,
  input  logic [CNTW-1:0]  scan_idx,
  output dp_status_t       status,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  logic [KEY_W-1:0] key_mem [SLOT_COUNT];
  logic [MS_W-1:0]  el_mem  [SLOT_COUNT];

  logic [SLOT_COUNT-1:0] valid_r;
  logic [INC_W-1:0]      tick_inc_r;
  in_item_t              item_r;

  logic [KEY_W-1:0] key_rd_r;
  logic [MS_W-1:0]  el_rd_r;
  logic [IDXW-1:0]  proc_idx_r;

  logic             hit_r, free_r;
  logic [IDXW-1:0]  hit_idx_r, free_idx_r;
  logic [MS_W-1:0]  hit_el_r;

  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             proc_valid;
  logic [MS_W:0]    sum;
  logic [MS_W-1:0]  sat_sum;
  logic             el_wr_en;
  logic [IDXW-1:0]  el_wr_idx;
  logic [MS_W-1:0]  el_wr_data;
  logic             take_slot;
  out_item_t        result;

  assign proc_valid = valid_r[proc_idx_r];
  assign sum        = {1'b0, el_rd_r} + {{(MS_W + 1 - INC_W){1'b0}}, tick_inc_r};
  assign sat_sum    = sum[MS_W] ? {MS_W{1'b1}} : sum[MS_W-1:0];

  // new key goes into the first free slot
  assign take_slot = cmd.commit && (item_r.req_type == REQ_CHECK) && !hit_r && free_r;

  always_comb begin
    el_wr_en   = 1'b0;
    el_wr_idx  = proc_idx_r;
    el_wr_data = sat_sum;
    if (take_slot) begin
      el_wr_en   = 1'b1;
      el_wr_idx  = free_idx_r;
      el_wr_data = '0;
    end else if (cmd.scan_proc && (item_r.req_type == REQ_TICK) && proc_valid) begin
      el_wr_en = 1'b1;
    end
  end

  always_comb begin
    result = '0;
    if (item_r.req_type == REQ_CHECK) begin
      if (hit_r) begin
        result.elapsed_ms = hit_el_r;
      end else begin
        result.table_full = !free_r;
      end
      result.expired = (result.elapsed_ms >= item_r.target_ms);
    end
  end

  // slot memories: one read and one write port each
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      key_rd_r   <= key_mem[scan_idx[IDXW-1:0]];
      el_rd_r    <= el_mem[scan_idx[IDXW-1:0]];
      proc_idx_r <= scan_idx[IDXW-1:0];
    end
    if (el_wr_en) begin
      el_mem[el_wr_idx] <= el_wr_data;
    end
    if (take_slot) begin
      key_mem[free_idx_r] <= item_r.timer_key;
    end
  end

  // transaction and search trackers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.load_item) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (cmd.scan_proc) begin
      if (proc_valid && (key_rd_r == item_r.timer_key) && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= proc_idx_r;
        hit_el_r  <= el_rd_r;
      end
      if (!proc_valid && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= proc_idx_r;
      end
    end
    if (cmd.commit) begin
      out_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      tick_inc_r  <= TICK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tick_inc_r <= cfg_wr_data;
      end
      if (take_slot) begin
        valid_r[free_idx_r] <= 1'b1;
      end else if (cmd.commit && (item_r.req_type == REQ_DESTROY) && hit_r) begin
        valid_r[hit_idx_r] <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

// ----- rtl/core/keyed_software_timer_bank.sv -----
// ----------------------------------------------------------------------------
// keyed_software_timer_bank
// Table of keyed elapsed-time counters with tick, check and destroy requests.
// ----------------------------------------------------------------------------
// Transactions: one at a time; a new request is accepted only after the
//   previous result has been committed to the output register. The sweep
//   covers one slot per cycle over the key and count memories.
// Reset: synchronous, active low; clears slot valid bits, the output valid and
//   loads tick_increment with 10. No clearing pass over the memories.
// ----------------------------------------------------------------------------
module keyed_software_timer_bank
  import kstb_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration: tick_increment
  input  logic             cfg_wr_en,
  input  logic [INC_W-1:0] cfg_wr_data,
  // request channel
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  localparam int CNTW = $clog2(SLOT_COUNT + 1);

  // Controller walks scan_idx from 0 to SLOT_COUNT; the datapath reads slot i
  // on one cycle and evaluates it on the next (registered memory read). Ticks
  // write back the saturated count in that evaluating cycle. Checks and destroys
  // track the first valid key match and the first free slot; the table and
  // the result register are updated in one commit cycle once the output
  // register is free. A pending result holds only the next commit, not its scan.
  ctl_cmd_t        cmd;
  dp_status_t      status;
  logic [CNTW-1:0] scan_idx;

  kstb_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .scan_idx (scan_idx)
  );

  kstb_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .scan_idx    (scan_idx),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ----- rtl/core/kstb_checker.sv -----
// ----------------------------------------------------------------------------
// kstb_checker
// Port-level assertions for the keyed software timer bank.
// ----------------------------------------------------------------------------
module kstb_checker
  import kstb_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one transaction in flight: the cycle after acceptance input is stalled
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("transaction accepted while busy");

  // a full table reports a zero count
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.table_full |-> out_data.elapsed_ms == '0)
    else $error("table_full with nonzero elapsed");

  // the sweep takes time: no fresh result right after acceptance
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind keyed_software_timer_bank kstb_checker u_kstb_checker (.*);
